FILE: rtl/i2cmbx_pkg.sv
// Shared types, codes and defaults of the I2C target command mailbox.
`timescale 1ns / 1ps

package i2cmbx_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int MAX_TEXT_DEF    = 64;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_OPCODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 1'b1;

  localparam logic [7:0] TEXT_OPCODE_RST = 8'hA6;
  localparam logic [6:0] MAX_LEN_RST     = 7'd64;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_EMPTY  = 2'd1,
    OP_POP    = 2'd2,
    OP_STATUS = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_NOCMD  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // input transfer completes this cycle
    logic copy_rd;    // read next capture byte for the slot copy
    logic pop_rd;     // read next byte of the popped slot
    logic pop_load;   // load the read byte into the output register
    logic resp_load;  // load a single no-command or status result
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic push_go;    // this write byte queues a command
    logic pop_hit;    // a command is waiting at the head
    logic copy_last;  // the current copy read is the final one
    logic pop_last;   // the current pop byte is the final one
    logic out_free;   // the output register can take a result
  } dp_stat_t;

endpackage

FILE: rtl/i2cmbx_ctrl.sv
// Controller state machine of the I2C target command mailbox.
`timescale 1ns / 1ps

module i2cmbx_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [1:0]             in_op,
  input  i2cmbx_pkg::dp_stat_t   stat,
  output i2cmbx_pkg::ctrl_cmd_t  cmd,
  output logic                   in_stall
);
  import i2cmbx_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_COPY     = 5'b00010,
    ST_POP_RD   = 5'b00100,
    ST_POP_WAIT = 5'b01000,
    ST_RESP     = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          priority if (in_op == OP_WRITE) begin
            if (stat.push_go) state_nxt = ST_COPY;
          end else if (in_op == OP_POP) begin
            state_nxt = stat.pop_hit ? ST_POP_RD : ST_RESP;
          end else if (in_op == OP_STATUS) begin
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_COPY: begin
        cmd.copy_rd = 1'b1;
        if (stat.copy_last) state_nxt = ST_IDLE;
      end
      ST_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_nxt  = ST_POP_WAIT;
      end
      ST_POP_WAIT: begin
        if (stat.out_free) begin
          cmd.pop_load = 1'b1;
          state_nxt    = stat.pop_last ? ST_IDLE : ST_POP_RD;
        end
      end
      ST_RESP: begin
        if (stat.out_free) begin
          cmd.resp_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/i2cmbx_dp.sv
// Datapath of the I2C target command mailbox: capture, queue, counters, result register.
`timescale 1ns / 1ps

module i2cmbx_dp #(
  parameter int QUEUE_DEPTH = i2cmbx_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_TEXT    = i2cmbx_pkg::MAX_TEXT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [i2cmbx_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [i2cmbx_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [1:0]                             in_op,
  input  logic [7:0]                             in_data_in,
  input  logic                                   in_first_byte,
  input  logic                                   in_last_byte,
  input  i2cmbx_pkg::ctrl_cmd_t                  cmd,
  output i2cmbx_pkg::dp_stat_t                   stat,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic [1:0]                             out_kind,
  output logic [7:0]                             out_data_out,
  output logic                                   out_last_of_run,
  output logic [$clog2(MAX_TEXT+1)-1:0]          out_cmd_len,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]       out_queue_count,
  output logic [31:0]                            out_dropped_total,
  output logic [31:0]                            out_rx_count,
  output logic [31:0]                            out_tx_count,
  output logic [7:0]                             out_last_rx_len
);
  import i2cmbx_pkg::*;

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH+1);
  localparam int LEN_W   = $clog2(MAX_TEXT+1);
  localparam int CAP_AW  = $clog2(MAX_TEXT);
  localparam int SLOT_N  = QUEUE_DEPTH * MAX_TEXT;
  localparam int SLOT_AW = $clog2(SLOT_N);

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_TEXT    = 2'd1,
    MODE_DISCARD = 2'd2
  } mode_t;

  // Configuration and control state.
  logic [7:0]       text_op_r;
  logic [6:0]       max_len_r;
  mode_t            mode_r;
  logic [LEN_W-1:0] cap_len_r;
  logic [7:0]       txn_bytes_r;
  logic [PTR_W-1:0] head_r, tail_r;
  logic [CNT_W-1:0] count_r;
  logic [31:0]      drop_r, rx_r, tx_r;
  logic [7:0]       last_len_r;
  logic [LEN_W-1:0] slot_len_r [QUEUE_DEPTH];
  logic             wr_pend_r;
  logic             out_valid_r;

  // Sequencing payload.
  kind_t            resp_kind_r;
  logic [PTR_W-1:0] copy_slot_r, pop_slot_r;
  logic [LEN_W-1:0] copy_len_r, copy_idx_r, wr_idx_r;
  logic [LEN_W-1:0] pop_len_r, pop_idx_r;
  logic [7:0]       cap_rd_r, slot_rd_r;

  // Output register payload.
  kind_t            out_kind_r;
  logic [7:0]       out_data_r;
  logic             out_last_r;
  logic [LEN_W-1:0] out_len_r;
  logic [CNT_W-1:0] out_count_r;
  logic [31:0]      out_drop_r, out_rx_r, out_tx_r;
  logic [7:0]       out_last_len_r;

  logic [7:0] cap_mem  [MAX_TEXT];
  logic [7:0] slot_mem [SLOT_N];

  // Write byte evaluation.
  logic [LEN_W-1:0] limit;
  mode_t            mode_w;
  logic [LEN_W-1:0] cap_w;
  logic [7:0]       tb_w;
  logic             cap_we, active, close, push_ok, full, out_load;
  logic [SLOT_AW-1:0] wr_addr, rd_addr;

  assign limit = (int'(max_len_r) < MAX_TEXT) ? LEN_W'(max_len_r) : LEN_W'(MAX_TEXT);

  always_comb begin
    mode_w = mode_r;
    cap_w  = cap_len_r;
    tb_w   = txn_bytes_r;
    cap_we = 1'b0;
    active = 1'b1;
    if (in_first_byte) begin
      mode_w = (in_data_in == text_op_r) ? MODE_TEXT : MODE_DISCARD;
      cap_w  = '0;
      tb_w   = 8'd1;
    end else if (mode_r == MODE_IDLE) begin
      active = 1'b0;
    end else begin
      tb_w = txn_bytes_r + 8'd1;
      if (mode_r == MODE_TEXT && cap_len_r < limit) begin
        cap_we = 1'b1;
        cap_w  = cap_len_r + LEN_W'(1);
      end
    end
  end

  assign close   = active && in_last_byte;
  assign push_ok = close && (mode_w == MODE_TEXT) && (cap_w != '0);
  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));

  assign stat.push_go   = (in_op == OP_WRITE) && push_ok && !full;
  assign stat.pop_hit   = (count_r != '0) && (slot_len_r[head_r] != '0);
  assign stat.copy_last = (LEN_W'(copy_idx_r + LEN_W'(1)) == copy_len_r);
  assign stat.pop_last  = (LEN_W'(pop_idx_r + LEN_W'(1)) == pop_len_r);
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign out_load = cmd.pop_load || cmd.resp_load;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH-1)) ? '0 : PTR_W'(p + PTR_W'(1));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_op_r   <= TEXT_OPCODE_RST;
      max_len_r   <= MAX_LEN_RST;
      mode_r      <= MODE_IDLE;
      cap_len_r   <= '0;
      txn_bytes_r <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      drop_r      <= '0;
      rx_r        <= '0;
      tx_r        <= '0;
      last_len_r  <= '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) slot_len_r[i] <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_TEXT_OPCODE: text_op_r <= cfg_data;
          CFG_MAX_LEN:     max_len_r <= cfg_data[6:0];
        endcase
      end
      if (cmd.accept) begin
        unique case (in_op)
          OP_WRITE: begin
            if (close) begin
              rx_r        <= rx_r + 32'd1;
              last_len_r  <= tb_w;
              mode_r      <= MODE_IDLE;
              cap_len_r   <= '0;
              txn_bytes_r <= '0;
              if (push_ok) begin
                if (full) begin
                  drop_r <= drop_r + 32'd1;
                end else begin
                  slot_len_r[tail_r] <= cap_w;
                  tail_r             <= ptr_inc(tail_r);
                  count_r            <= count_r + CNT_W'(1);
                end
              end
            end else begin
              mode_r      <= mode_w;
              cap_len_r   <= cap_w;
              txn_bytes_r <= tb_w;
            end
          end
          OP_EMPTY: begin
            last_len_r  <= '0;
            mode_r      <= MODE_IDLE;
            cap_len_r   <= '0;
            txn_bytes_r <= '0;
          end
          OP_POP: begin
            if (stat.pop_hit) begin
              slot_len_r[head_r] <= '0;
              head_r             <= ptr_inc(head_r);
              count_r            <= count_r - CNT_W'(1);
            end
          end
          OP_STATUS: tx_r <= tx_r + 32'd1;
        endcase
      end
      wr_pend_r <= cmd.copy_rd;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      copy_slot_r <= tail_r;
      copy_len_r  <= cap_w;
      copy_idx_r  <= '0;
      pop_slot_r  <= head_r;
      pop_len_r   <= slot_len_r[head_r];
      pop_idx_r   <= '0;
      resp_kind_r <= (in_op == OP_STATUS) ? KIND_STATUS : KIND_NOCMD;
    end
    if (cmd.copy_rd) begin
      copy_idx_r <= copy_idx_r + LEN_W'(1);
      wr_idx_r   <= copy_idx_r;
    end
    if (cmd.pop_load) begin
      pop_idx_r <= pop_idx_r + LEN_W'(1);
    end
    if (out_load) begin
      out_count_r    <= count_r;
      out_drop_r     <= drop_r;
      out_rx_r       <= rx_r;
      out_tx_r       <= tx_r;
      out_last_len_r <= last_len_r;
      if (cmd.pop_load) begin
        out_kind_r <= KIND_BYTE;
        out_data_r <= slot_rd_r;
        out_last_r <= stat.pop_last;
        out_len_r  <= pop_len_r;
      end else begin
        out_kind_r <= resp_kind_r;
        out_data_r <= '0;
        out_last_r <= 1'b1;
        out_len_r  <= '0;
      end
    end
  end

  // Capture store: filled as text bytes arrive, read out during the slot copy.
  always_ff @(posedge clk) begin
    if (cmd.accept && in_op == OP_WRITE && cap_we) begin
      cap_mem[cap_len_r[CAP_AW-1:0]] <= in_data_in;
    end
    if (cmd.copy_rd) begin
      cap_rd_r <= cap_mem[copy_idx_r[CAP_AW-1:0]];
    end
  end

  assign wr_addr = SLOT_AW'(int'(copy_slot_r) * MAX_TEXT + int'(wr_idx_r));
  assign rd_addr = SLOT_AW'(int'(pop_slot_r) * MAX_TEXT + int'(pop_idx_r));

  // Slot store: one row of MAX_TEXT bytes per queue slot.
  always_ff @(posedge clk) begin
    if (wr_pend_r) begin
      slot_mem[wr_addr] <= cap_rd_r;
    end
    if (cmd.pop_rd) begin
      slot_rd_r <= slot_mem[rd_addr];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_data_out      = out_data_r;
  assign out_last_of_run   = out_last_r;
  assign out_cmd_len       = out_len_r;
  assign out_queue_count   = out_count_r;
  assign out_dropped_total = out_drop_r;
  assign out_rx_count      = out_rx_r;
  assign out_tx_count      = out_tx_r;
  assign out_last_rx_len   = out_last_len_r;

endmodule

FILE: rtl/i2c_target_command_mailbox.sv
// Top level of the I2C target command mailbox: controller and datapath.
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in_       in         in_valid / in_stall   op, data_in, first_byte, last_byte
// out_      out        out_valid / out_stall kind, data_out, last_of_run, cmd_len,
//                                            queue_count, dropped_total, rx_count,
//                                            tx_count, last_rx_len
// cfg_      in         cfg_wr_en             cfg_index, cfg_data
//
// A write byte or empty transaction is taken in the idle state. A closing byte that
// queues a command then copies the capture store into the slot store, one payload
// byte per cycle. A pop is accepted and then, for each command byte, reads the slot
// store and then loads the output register, waiting while the output is stalled;
// a no-command or status result is loaded once the output register is free.
// Reset is synchronous and needs no clearing pass; a stalled output holds the
// current transfer and the controller waits before loading the next result.
module i2c_target_command_mailbox #(
  parameter int QUEUE_DEPTH = i2cmbx_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_TEXT    = i2cmbx_pkg::MAX_TEXT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [i2cmbx_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [i2cmbx_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_op,
  input  logic [7:0]                             in_data_in,
  input  logic                                   in_first_byte,
  input  logic                                   in_last_byte,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [1:0]                             out_kind,
  output logic [7:0]                             out_data_out,
  output logic                                   out_last_of_run,
  output logic [$clog2(MAX_TEXT+1)-1:0]          out_cmd_len,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]       out_queue_count,
  output logic [31:0]                            out_dropped_total,
  output logic [31:0]                            out_rx_count,
  output logic [31:0]                            out_tx_count,
  output logic [7:0]                             out_last_rx_len
);
  import i2cmbx_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // The controller only sequences; every store and counter lives in the datapath.
  i2cmbx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  i2cmbx_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_TEXT    (MAX_TEXT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_op             (in_op),
    .in_data_in        (in_data_in),
    .in_first_byte     (in_first_byte),
    .in_last_byte      (in_last_byte),
    .cmd               (cmd),
    .stat              (stat),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_data_out      (out_data_out),
    .out_last_of_run   (out_last_of_run),
    .out_cmd_len       (out_cmd_len),
    .out_queue_count   (out_queue_count),
    .out_dropped_total (out_dropped_total),
    .out_rx_count      (out_rx_count),
    .out_tx_count      (out_tx_count),
    .out_last_rx_len   (out_last_rx_len)
  );

  // A pop or status transfer always leaves the block busy for the next cycle.
  a_resp_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_op == OP_POP || in_op == OP_STATUS)) |=> in_stall)
    else $error("input taken straight after a pop or status transfer");

  // Single results always close their run.
  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_BYTE) |-> out_last_of_run)
    else $error("no-command or status result without last_of_run");

  // The reported queue occupancy never exceeds the number of slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_queue_count) <= QUEUE_DEPTH))
    else $error("queue count above depth");

  // Reset empties the output register.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result still valid after reset");

endmodule

FILE: tb/tb_i2c_target_command_mailbox.sv
// Self-checking testbench for the I2C target command mailbox.
`timescale 1ns / 1ps

module tb_i2c_target_command_mailbox;
  import i2cmbx_pkg::*;

  localparam int QDEPTH  = QUEUE_DEPTH_DEF;
  localparam int MAXTXT  = MAX_TEXT_DEF;
  localparam logic [7:0] POKE_OP = 8'hA5;
  // A closing byte may still be copying a full payload into its slot after the
  // last predicted result has gone, so the block is given this long to settle.
  localparam int SETTLE_CYCLES = 2 * MAXTXT + 16;
  // Cycles without any transfer on either channel before the run is abandoned.
  localparam int STALL_LIMIT   = 4000;

  typedef enum int {CAP_IDLE, CAP_TEXT, CAP_DISCARD} capture_mode_t;

  // One result as it should appear on the output channel.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        last;
    logic [6:0]  len;
    logic [2:0]  qcnt;
    logic [31:0] drops;
    logic [31:0] rx;
    logic [31:0] tx;
    logic [7:0]  rxlen;
  } mbx_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TEXT_OPCODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = OP_WRITE;
  logic [7:0]  in_data_in = '0;
  logic        in_first_byte = 1'b0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_out;
  logic        out_last_of_run;
  logic [6:0]  out_cmd_len;
  logic [2:0]  out_queue_count;
  logic [31:0] out_dropped_total;
  logic [31:0] out_rx_count;
  logic [31:0] out_tx_count;
  logic [7:0]  out_last_rx_len;

  i2c_target_command_mailbox u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_data_in        (in_data_in),
    .in_first_byte     (in_first_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_data_out      (out_data_out),
    .out_last_of_run   (out_last_of_run),
    .out_cmd_len       (out_cmd_len),
    .out_queue_count   (out_queue_count),
    .out_dropped_total (out_dropped_total),
    .out_rx_count      (out_rx_count),
    .out_tx_count      (out_tx_count),
    .out_last_rx_len   (out_last_rx_len)
  );

  // The clock runs with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Mailbox predictor: its own copy of the registers, the ring queue, the
  // capture buffer and the counters, advanced once per accepted input transfer.
  // ---------------------------------------------------------------------------
  logic [7:0]    cfg_text_op = TEXT_OPCODE_RST;
  logic [6:0]    cfg_max_len = MAX_LEN_RST;

  logic [7:0]    mb_slot_bytes [QDEPTH][MAXTXT];
  int            mb_slot_len [QDEPTH];
  int            mb_head = 0;
  int            mb_tail = 0;
  int            mb_count = 0;
  logic [31:0]   mb_drops = '0;
  logic [31:0]   mb_rx = '0;
  logic [31:0]   mb_tx = '0;
  logic [7:0]    mb_last_len = '0;
  logic [7:0]    mb_capture [MAXTXT];
  int            mb_cap_len = 0;
  capture_mode_t mb_mode = CAP_IDLE;
  logic [7:0]    mb_txn_bytes = '0;

  // Results predicted but not yet seen on the output channel, oldest first.
  mbx_reply_t    predicted_replies [$];

  int error_count = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    for (int s = 0; s < QDEPTH; s++) begin
      mb_slot_len[s] = 0;
    end
  end

  function automatic void push_reply(kind_t k, logic [7:0] d, logic lst, int len);
    mbx_reply_t r;
    r.kind  = k;
    r.data  = d;
    r.last  = lst;
    r.len   = 7'(len);
    r.qcnt  = 3'(mb_count);
    r.drops = mb_drops;
    r.rx    = mb_rx;
    r.tx    = mb_tx;
    r.rxlen = mb_last_len;
    predicted_replies.push_back(r);
  endfunction

  // Moves a finished text payload into the tail slot, or counts it as dropped
  // when every slot is taken. An empty payload is never queued.
  function automatic void queue_capture();
    if (mb_cap_len == 0) begin
      return;
    end
    if (mb_count >= QDEPTH) begin
      mb_drops = mb_drops + 1;
      return;
    end
    for (int i = 0; i < mb_cap_len; i++) begin
      mb_slot_bytes[mb_tail][i] = mb_capture[i];
    end
    mb_slot_len[mb_tail] = mb_cap_len;
    mb_tail  = (mb_tail + 1) % QDEPTH;
    mb_count = mb_count + 1;
  endfunction

  function automatic void predict_mailbox_item(op_t op, logic [7:0] d, logic first,
                                               logic lst);
    int limit;
    int slot;
    int n;
    limit = (int'(cfg_max_len) < MAXTXT) ? int'(cfg_max_len) : MAXTXT;
    case (op)
      OP_WRITE: begin
        // A non-first byte with nothing open is simply ignored.
        if (first || mb_mode != CAP_IDLE) begin
          if (first) begin
            mb_mode      = (d == cfg_text_op) ? CAP_TEXT : CAP_DISCARD;
            mb_cap_len   = 0;
            mb_txn_bytes = 8'd1;
          end else begin
            mb_txn_bytes = mb_txn_bytes + 8'd1;
            if (mb_mode == CAP_TEXT && mb_cap_len < limit) begin
              mb_capture[mb_cap_len] = d;
              mb_cap_len = mb_cap_len + 1;
            end
          end
          if (lst) begin
            mb_rx       = mb_rx + 1;
            mb_last_len = mb_txn_bytes;
            if (mb_mode == CAP_TEXT) begin
              queue_capture();
            end
            mb_mode      = CAP_IDLE;
            mb_cap_len   = 0;
            mb_txn_bytes = '0;
          end
        end
      end
      OP_EMPTY: begin
        mb_last_len  = '0;
        mb_mode      = CAP_IDLE;
        mb_cap_len   = 0;
        mb_txn_bytes = '0;
      end
      OP_POP: begin
        if (mb_count == 0 || mb_slot_len[mb_head] == 0) begin
          push_reply(KIND_NOCMD, 8'h00, 1'b1, 0);
        end else begin
          slot = mb_head;
          n    = (mb_slot_len[slot] > MAXTXT) ? MAXTXT : mb_slot_len[slot];
          mb_slot_len[slot] = 0;
          mb_head  = (mb_head + 1) % QDEPTH;
          mb_count = mb_count - 1;
          for (int i = 0; i < n; i++) begin
            push_reply(KIND_BYTE, mb_slot_bytes[slot][i], i == n - 1, n);
          end
        end
      end
      default: begin
        mb_tx = mb_tx + 1;
        push_reply(KIND_STATUS, 8'h00, 1'b1, 0);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every output transfer is compared with the oldest
  // prediction, field by field.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t ns", what, got, want, $time);
    error_count++;
  endtask

  mbx_reply_t head_reply;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_replies.size() == 0) begin
        report_mismatch("result with nothing predicted, kind", out_kind, 32'd0);
      end else begin
        head_reply = predicted_replies.pop_front();
        if (out_kind !== head_reply.kind)
          report_mismatch("kind", out_kind, head_reply.kind);
        if (out_data_out !== head_reply.data)
          report_mismatch("data_out", out_data_out, head_reply.data);
        if (out_last_of_run !== head_reply.last)
          report_mismatch("last_of_run", out_last_of_run, head_reply.last);
        if (out_cmd_len !== head_reply.len)
          report_mismatch("cmd_len", out_cmd_len, head_reply.len);
        if (out_queue_count !== head_reply.qcnt)
          report_mismatch("queue_count", out_queue_count, head_reply.qcnt);
        if (out_dropped_total !== head_reply.drops)
          report_mismatch("dropped_total", out_dropped_total, head_reply.drops);
        if (out_rx_count !== head_reply.rx)
          report_mismatch("rx_count", out_rx_count, head_reply.rx);
        if (out_tx_count !== head_reply.tx)
          report_mismatch("tx_count", out_tx_count, head_reply.tx);
        if (out_last_rx_len !== head_reply.rxlen)
          report_mismatch("last_rx_len", out_last_rx_len, head_reply.rxlen);
      end
    end
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: a run in which neither channel completes a transfer for this long
  // has hung, or a predicted result never arrived.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, predicted_replies.size());
      $display("** i2c_target_command_mailbox: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Every task is entered and left just after a falling edge.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  // Offers one item and holds it until the input transfer completes; the
  // prediction is made at the edge where the block takes it.
  task automatic send_item(op_t op, logic [7:0] d, logic first, logic lst);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_data_in    <= d;
    in_first_byte <= first;
    in_last_byte  <= lst;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_mailbox_item(op, d, first, lst);
    items_sent++;
    @(negedge clk);
  endtask

  // Pops and status requests carry random, ignored byte and flag fields.
  task automatic send_pop();
    send_item(OP_POP, rand_byte(), rand_bit(), rand_bit());
  endtask

  task automatic send_status();
    send_item(OP_STATUS, rand_byte(), rand_bit(), rand_bit());
  endtask

  // A complete write transaction: opcode byte followed by random payload bytes.
  task automatic send_txn(logic [7:0] opcode, int payload);
    send_item(OP_WRITE, opcode, 1'b1, payload == 0);
    for (int i = 1; i <= payload; i++) begin
      send_item(OP_WRITE, rand_byte(), 1'b0, i == payload);
    end
  endtask

  // Drops valid and waits until every predicted result has been taken, then
  // gives a closing slot copy time to finish.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (predicted_replies.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    if (idx == CFG_TEXT_OPCODE) begin
      cfg_text_op = value;
    end else begin
      cfg_max_len = value[6:0];
    end
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Counters straight after reset, and a pop from an empty queue.
  task automatic test_reset_state();
    send_status();
    send_pop();
  endtask

  // A text command with extreme payload bytes, an opcode-only transaction that
  // counts but queues nothing, then one pop for the queued command.
  task automatic test_text_capture();
    send_item(OP_WRITE, cfg_text_op, 1'b1, 1'b0);
    send_item(OP_WRITE, 8'h00, 1'b0, 1'b0);
    send_item(OP_WRITE, 8'hFF, 1'b0, 1'b1);
    send_item(OP_WRITE, cfg_text_op, 1'b1, 1'b1);
    send_pop();
  endtask

  // Poke and unknown opcodes are counted but their payloads are thrown away.
  task automatic test_poke_and_unknown();
    send_item(OP_WRITE, POKE_OP, 1'b1, 1'b0);
    send_item(OP_WRITE, 8'h5A, 1'b0, 1'b1);
    send_item(OP_WRITE, 8'h00, 1'b1, 1'b0);
    send_item(OP_WRITE, 8'hC3, 1'b0, 1'b1);
    send_status();
  endtask

  // A stray closing byte with nothing open, and a transaction abandoned by a
  // fresh opcode byte before it was closed.
  task automatic test_stray_and_restart();
    send_item(OP_WRITE, 8'h81, 1'b0, 1'b1);
    send_item(OP_WRITE, cfg_text_op, 1'b1, 1'b0);
    send_item(OP_WRITE, 8'h11, 1'b0, 1'b0);
    send_item(OP_WRITE, cfg_text_op, 1'b1, 1'b0);
    send_item(OP_WRITE, 8'h22, 1'b0, 1'b1);
    send_pop();
  endtask

  // An empty transaction abandons an open capture; a pop and a status request
  // in the middle of a transaction leave its capture intact.
  task automatic test_empty_and_midway();
    send_item(OP_WRITE, cfg_text_op, 1'b1, 1'b0);
    send_item(OP_WRITE, 8'h33, 1'b0, 1'b0);
    send_item(OP_EMPTY, rand_byte(), rand_bit(), rand_bit());
    send_item(OP_WRITE, 8'h44, 1'b0, 1'b1);
    send_item(OP_WRITE, cfg_text_op, 1'b1, 1'b0);
    send_item(OP_WRITE, 8'h55, 1'b0, 1'b0);
    send_pop();
    send_status();
    send_item(OP_WRITE, 8'h66, 1'b0, 1'b1);
    send_pop();
  endtask

  // A 256 byte text transaction: the payload is cut at the capture limit and
  // the transaction length wraps to zero in last_rx_len.
  task automatic test_length_wrap();
    send_txn(cfg_text_op, 255);
    send_status();
    send_pop();
  endtask

  // ---------------------------------------------------------------------------
  // Random phases: mostly well-formed transactions with random content, mixed
  // with pops, status requests and broken or interrupted transactions.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_opcode();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return cfg_text_op;
    if (sel < 80) return POKE_OP;
    return rand_byte();
  endfunction

  function automatic int pick_payload();
    if ($urandom_range(99) < 6) return $urandom_range(60, 70);
    return $urandom_range(0, 5);
  endfunction

  task automatic test_random_phase(logic [7:0] opcode, logic [6:0] max_len,
                                   int send_pct, int recv_pct, int n_items);
    int start;
    int sel;
    wait_quiet();
    write_reg(CFG_TEXT_OPCODE, opcode);
    write_reg(CFG_MAX_LEN, {1'b0, max_len});
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start = items_sent;
    while (items_sent - start < n_items) begin
      sel = $urandom_range(99);
      if (sel < 50) begin
        send_txn(pick_opcode(), pick_payload());
      end else if (sel < 70) begin
        send_pop();
      end else if (sel < 78) begin
        send_status();
      end else begin
        case ($urandom_range(3))
          0: send_item(OP_WRITE, rand_byte(), 1'b0, rand_bit());
          1: begin
            // Left open: the next opcode byte or an empty transaction ends it.
            send_item(OP_WRITE, pick_opcode(), 1'b1, 1'b0);
            send_item(OP_WRITE, rand_byte(), 1'b0, 1'b0);
            if (rand_bit()) begin
              send_item(OP_EMPTY, rand_byte(), rand_bit(), rand_bit());
            end
          end
          2: send_item(OP_EMPTY, rand_byte(), rand_bit(), rand_bit());
          default: begin
            send_item(OP_WRITE, pick_opcode(), 1'b1, 1'b0);
            send_item(OP_WRITE, rand_byte(), 1'b0, 1'b0);
            send_pop();
            send_status();
            send_item(OP_WRITE, rand_byte(), 1'b0, 1'b1);
          end
        endcase
      end
    end
    // Empty the queue so that the next phase starts from a known fill level.
    while (mb_count > 0) begin
      send_pop();
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_text_capture();
    test_poke_and_unknown();
    test_stray_and_restart();
    test_empty_and_midway();
    test_length_wrap();

    // Register settings run from one extreme to the other; a zero capture
    // limit keeps nothing, and an opcode equal to the poke code selects text.
    test_random_phase(8'hA6, 7'd64,  0,  0, 12);
    test_random_phase(8'h00, 7'd1,  83,  0, 10);
    test_random_phase(8'hA5, 7'd7,   0, 83, 10);
    test_random_phase(8'hFF, 7'd0,  20, 20,  8);
    test_random_phase(8'h5A, 7'd64, 20, 20, 10);

    wait_quiet();
    if (error_count == 0) begin
      $display("** i2c_target_command_mailbox: PASSED **");
    end else begin
      $display("** i2c_target_command_mailbox: FAILED **");
    end
    $finish;
  end

endmodule

FILE: i2c_target_command_mailbox.f
rtl/i2cmbx_pkg.sv
rtl/i2cmbx_ctrl.sv
rtl/i2cmbx_dp.sv
rtl/i2c_target_command_mailbox.sv
tb/tb_i2c_target_command_mailbox.sv
